[rtl/cdlb_pkg.sv]
// cdlb_pkg: shared types, constants and fixed-point helpers for the color dodge blend
// depends on: nothing
package cdlb_pkg;

  // channel word width and the fixed-point value of 1.0
  localparam int CW = 16;
  localparam logic [CW-1:0] ONE = {CW{1'b1}};
  localparam logic [2*CW:0] HALF = {{(CW+2){1'b0}}, {(CW-1){1'b1}}};

  // register indexes of the configuration port
  localparam logic REG_OPACITY = 1'b0;
  localparam logic REG_MASK_EN = 1'b1;

  // pipeline stage where the alpha path finishes and where the blend leaves
  localparam int ALPHA_STAGE = 6;
  localparam int DIV_LAT = CW + 1;
  localparam int MIX_STAGE = ALPHA_STAGE + DIV_LAT + 2;
  localparam int OUT_STAGE = MIX_STAGE + 1;

  // one pixel pair as it travels down the pipeline
  typedef struct packed {
    logic [3:0][CW-1:0] base;
    logic [3:0][CW-1:0] layer;
    logic [CW-1:0]      mask;
    logic               last;
  } pixel_t;

  // rounded quotient by ONE for values up to ONE*ONE + ONE/2
  function automatic logic [CW-1:0] div_one(input logic [2*CW:0] x);
    logic [CW:0]   q0;
    logic [CW+1:0] r;
    q0 = x[2*CW:CW];
    r = {2'b00, x[CW-1:0]} + {1'b0, q0};
    if (r >= {2'b00, ONE}) begin
      q0 = q0 + 1'b1;
    end
    return q0[CW-1:0];
  endfunction

endpackage

[rtl/cdlb_divider.sv]
// cdlb_divider: pipelined saturating fraction divider, round(num*ONE/den) clipped to ONE
// depends on: cdlb_pkg
module cdlb_divider import cdlb_pkg::*; (
  input  logic          clk,
  input  logic          en,
  input  logic [CW-1:0] num,
  input  logic [CW-1:0] den,
  output logic [CW-1:0] q
);

  logic [2*CW:0] dividend;
  logic [CW-1:0] rem  [0:CW];
  logic [CW-1:0] low  [0:CW];
  logic [CW-1:0] quo  [0:CW];
  logic [CW-1:0] dv   [0:CW];
  logic          sat  [0:CW];

  // scaled dividend with half-divisor rounding term
  assign dividend = {1'b0, num, {CW{1'b0}}} - {{(CW+1){1'b0}}, num}
                  + {{(CW+2){1'b0}}, den[CW-1:1]};

  // load stage: saturate when the quotient would reach ONE or the divisor is zero
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= dividend[2*CW-1:CW];
      low[0] <= dividend[CW-1:0];
      quo[0] <= '0;
      dv[0]  <= den;
      sat[0] <= (den == '0) || (num >= den);
    end
  end

  // one restoring step per stage
  for (genvar i = 1; i <= CW; i++) begin : g_step
    logic [CW:0] part;
    logic [CW:0] diff;
    logic        fits;
    assign part = {rem[i-1], low[i-1][CW-1]};
    assign diff = part - {1'b0, dv[i-1]};
    assign fits = part >= {1'b0, dv[i-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem[i] <= fits ? diff[CW-1:0] : part[CW-1:0];
        low[i] <= {low[i-1][CW-2:0], 1'b0};
        quo[i] <= {quo[i-1][CW-2:0], fits};
        dv[i]  <= dv[i-1];
        sat[i] <= sat[i-1];
      end
    end
  end

  assign q = sat[CW] ? ONE : quo[CW];

endmodule

[rtl/cdlb_alpha.sv]
// cdlb_alpha: composite and new alpha, six registered stages
// depends on: cdlb_pkg
module cdlb_alpha import cdlb_pkg::*; (
  input  logic          clk,
  input  logic          en,
  input  logic [CW-1:0] opacity,
  input  logic          mask_enable,
  input  logic [CW-1:0] base_alpha,
  input  logic [CW-1:0] layer_alpha,
  input  logic [CW-1:0] mask_value,
  output logic [CW-1:0] comp,
  output logic [CW-1:0] fresh
);

  logic [CW-1:0]   mn;
  logic [2*CW-1:0] p1, p3, p5;
  logic [CW-1:0]   ba1, ba2, ba3, ba4, ba5;
  logic [CW-1:0]   mk1, mk2;
  logic [CW-1:0]   comp2, c3, comp4, c5;
  logic            m3;

  assign mn = (base_alpha < layer_alpha) ? base_alpha : layer_alpha;

  // min alpha times opacity, then rounding, then optional mask
  always_ff @(posedge clk) begin
    if (en) begin
      p1    <= mn * opacity;
      ba1   <= base_alpha;
      mk1   <= mask_value;
      comp2 <= div_one({1'b0, p1} + HALF);
      ba2   <= ba1;
      mk2   <= mk1;
      p3    <= comp2 * mk2;
      c3    <= comp2;
      m3    <= mask_enable;
      ba3   <= ba2;
      comp4 <= m3 ? div_one({1'b0, p3} + HALF) : c3;
      ba4   <= ba3;
    end
  end

  // new alpha = base + (1 - base) * comp
  always_ff @(posedge clk) begin
    if (en) begin
      p5    <= (ONE - ba4) * comp4;
      c5    <= comp4;
      ba5   <= ba4;
      fresh <= ba5 + div_one({1'b0, p5} + HALF);
      comp  <= c5;
    end
  end

endmodule

[rtl/cdlb_lane.sv]
// cdlb_lane: one colour channel, dodge divide then mix with the base by ratio
// depends on: cdlb_pkg, cdlb_divider
module cdlb_lane import cdlb_pkg::*; (
  input  logic          clk,
  input  logic          en,
  input  logic [CW-1:0] base_div,
  input  logic [CW-1:0] layer_div,
  input  logic [CW-1:0] base_mix,
  input  logic [CW-1:0] ratio,
  output logic [CW-1:0] mix
);

  logic [CW-1:0]   dodge;
  logic [2*CW-1:0] pa, pb;

  // dodge value base / (1 - layer)
  cdlb_divider u_div (
    .clk (clk),
    .en  (en),
    .num (base_div),
    .den (ONE - layer_div),
    .q   (dodge)
  );

  // weighted mix, rounded once
  always_ff @(posedge clk) begin
    if (en) begin
      pa  <= dodge * ratio;
      pb  <= base_mix * (ONE - ratio);
      mix <= div_one({1'b0, pa} + {1'b0, pb} + HALF);
    end
  end

endmodule

[rtl/color_dodge_layer_blend.sv]
// color_dodge_layer_blend: top level, input skid, alpha path, colour lanes and output merge
// depends on: cdlb_pkg, cdlb_alpha, cdlb_divider, cdlb_lane
//
// Blends one RGBA layer pixel onto one RGBA base pixel in color dodge mode and
// takes one pixel every clock unless the output stalls. From acceptance to the
// output register each pixel passes the composite and new alpha multiplies, the
// pipelined one-bit-per-stage dividers (ratio and three dodge lanes run side by
// side), the channel mix and the output merge. An input skid register keeps
// s_tready free of m_tready. Users must write opacity and mask enable through
// cfg_we / cfg_index / cfg_data only while no pixel is in flight; the block does not enforce it.
module color_dodge_layer_blend import cdlb_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [CW-1:0] cfg_data,
  input  logic          s_tvalid,
  output logic          s_tready,
  // base_red, base_green, base_blue, base_alpha, layer_red, layer_green,
  // layer_blue, layer_alpha, mask_value
  input  logic [9*CW-1:0] s_tdata,
  input  logic          s_tlast,
  output logic          m_tvalid,
  input  logic          m_tready,
  // out_red, out_green, out_blue, out_alpha
  output logic [4*CW-1:0] m_tdata,
  output logic          m_tlast
);

  logic [CW-1:0] opacity;
  logic          mask_enable;
  pixel_t        pix_in, skid;
  logic          skid_valid;
  logic          en, load;
  logic [OUT_STAGE:0] vld;
  pixel_t        pay  [0:MIX_STAGE];
  logic          pass [ALPHA_STAGE+1:MIX_STAGE];
  logic [CW-1:0] comp, fresh, ratio;
  logic [CW-1:0] mix  [0:2];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      opacity     <= ONE;
      mask_enable <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OPACITY: opacity     <= cfg_data;
        REG_MASK_EN: mask_enable <= cfg_data[0];
        default:     opacity     <= opacity;
      endcase
    end
  end

  // unpack the input transaction
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      pix_in.base[c]  = s_tdata[c*CW +: CW];
      pix_in.layer[c] = s_tdata[(4+c)*CW +: CW];
    end
    pix_in.mask = s_tdata[8*CW +: CW];
    pix_in.last = s_tlast;
  end

  // pipeline advances unless the output register holds an untaken transaction
  assign en       = !vld[OUT_STAGE] || m_tready;
  assign s_tready = !skid_valid;
  assign load     = skid_valid || (s_tvalid && s_tready);

  // input skid register
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (en) begin
      skid_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!en && s_tvalid && s_tready) begin
      skid <= pix_in;
    end
  end

  // valid bits along the pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[OUT_STAGE-1:0], load};
    end
  end

  // pixel payload delay line
  always_ff @(posedge clk) begin
    if (en) begin
      pay[0] <= skid_valid ? skid : pix_in;
      for (int k = 1; k <= MIX_STAGE; k++) begin
        pay[k] <= pay[k-1];
      end
    end
  end

  // alpha path
  cdlb_alpha u_alpha (
    .clk         (clk),
    .en          (en),
    .opacity     (opacity),
    .mask_enable (mask_enable),
    .base_alpha  (pay[0].base[3]),
    .layer_alpha (pay[0].layer[3]),
    .mask_value  (pay[0].mask),
    .comp        (comp),
    .fresh       (fresh)
  );

  // pass-through flag follows the pixel
  always_ff @(posedge clk) begin
    if (en) begin
      pass[ALPHA_STAGE+1] <= (comp == '0) || (fresh == '0);
      for (int k = ALPHA_STAGE + 2; k <= MIX_STAGE; k++) begin
        pass[k] <= pass[k-1];
      end
    end
  end

  // mix ratio comp / new alpha
  cdlb_divider u_ratio (
    .clk (clk),
    .en  (en),
    .num (comp),
    .den (fresh),
    .q   (ratio)
  );

  // colour lanes
  for (genvar c = 0; c < 3; c++) begin : g_lane
    cdlb_lane u_lane (
      .clk       (clk),
      .en        (en),
      .base_div  (pay[ALPHA_STAGE].base[c]),
      .layer_div (pay[ALPHA_STAGE].layer[c]),
      .base_mix  (pay[ALPHA_STAGE+DIV_LAT].base[c]),
      .ratio     (ratio),
      .mix       (mix[c])
    );
  end

  // merge lanes into the output register
  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        m_tdata[c*CW +: CW] <= pass[MIX_STAGE] ? pay[MIX_STAGE].base[c] : mix[c];
      end
      m_tdata[3*CW +: CW] <= pay[MIX_STAGE].base[3];
      m_tlast <= pay[MIX_STAGE].last;
    end
  end

  assign m_tvalid = vld[OUT_STAGE];

  // skid fills only while the pipeline is held
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(!en))
    else $error("skid register filled while pipeline advanced");

  // a held skid entry drains on the next advance
  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    skid_valid && en |=> !skid_valid)
    else $error("skid entry not drained");

  // composite alpha never exceeds the new alpha
  a_alpha_order: assert property (@(posedge clk) disable iff (rst)
    vld[ALPHA_STAGE] |-> comp <= fresh)
    else $error("composite alpha above new alpha");

endmodule

[tb/color_dodge_layer_blend_tb.sv]
`timescale 1ns / 1ps
// color_dodge_layer_blend_tb: self-checking bench for the color dodge blend pipeline
// depends on: cdlb_pkg, color_dodge_layer_blend
module color_dodge_layer_blend_tb;
  import cdlb_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = OUT_STAGE + 10;
  localparam int SINK_HOLD_CYCLES = 150;

  typedef struct packed {
    logic [CW-1:0] br, bg, bb, ba, lr, lg, lb, la, mv;
    logic          last;
  } pix_in_t;

  typedef struct packed {
    logic [CW-1:0] r, g, b, a;
    logic          last;
  } pix_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_index = REG_OPACITY;
  logic [CW-1:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [9*CW-1:0] s_tdata = '0;
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [4*CW-1:0] m_tdata;
  logic m_tlast;

  // blend settings mirrored in the bench
  logic [CW-1:0] opacity_q = ONE;
  logic          mask_en_q = 1'b0;

  pix_in_t  pending_pixels[$];
  pix_out_t expected_pixels[$];
  int errors = 0;
  int pixels_sent = 0;
  int pixels_seen = 0;
  int idle_cycles = 0;
  bit calm = 1'b0;
  bit hold_sink = 1'b0;
  bit in_fire = 1'b0;

  color_dodge_layer_blend u_top (.*);

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // fixed-point helpers
  function automatic logic [63:0] fmul(input logic [63:0] a, input logic [63:0] b);
    return (a * b + ONE / 2) / ONE;
  endfunction

  function automatic logic [63:0] sat_quot(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    if (den == 0) return ONE;
    q = (num * ONE + den / 2) / den;
    return (q > ONE) ? ONE : q;
  endfunction

  function automatic pix_out_t dodge_blend(input pix_in_t p);
    logic [63:0] base_c[3], lay_c[3], comp, fresh, ratio, dv, mn;
    pix_out_t o;
    base_c = '{p.br, p.bg, p.bb};
    lay_c = '{p.lr, p.lg, p.lb};
    mn = (p.ba < p.la) ? p.ba : p.la;
    comp = fmul(mn, opacity_q);
    if (mask_en_q) comp = fmul(comp, p.mv);
    fresh = p.ba + fmul(ONE - p.ba, comp);
    if (comp != 0 && fresh != 0) begin
      ratio = sat_quot(comp, fresh);
      for (int c = 0; c < 3; c++) begin
        dv = sat_quot(base_c[c], ONE - lay_c[c]);
        base_c[c] = (dv * ratio + base_c[c] * (ONE - ratio) + ONE / 2) / ONE;
      end
    end
    o.r = base_c[0][CW-1:0];
    o.g = base_c[1][CW-1:0];
    o.b = base_c[2][CW-1:0];
    o.a = p.ba;
    o.last = p.last;
    return o;
  endfunction

  task automatic report_mismatch(input string what, input logic [CW-1:0] got,
                                 input logic [CW-1:0] want);
    errors++;
    $display("mismatch at result %0d: %s got %h expected %h", pixels_seen, what, got, want);
  endtask

  // input handshake as seen at the rising edge
  always @(posedge clk) begin
    in_fire <= !rst && s_tvalid && s_tready;
  end

  // driver: offers queued pixels with random gaps
  int src_gap = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (in_fire) begin
        void'(pending_pixels.pop_front());
      end
      if (src_gap > 0) begin
        src_gap--;
        s_tvalid <= 1'b0;
      end else if (pending_pixels.size() > 0 &&
                   !(in_fire && !calm && $urandom_range(0, 15) == 0)) begin
        s_tvalid <= 1'b1;
        s_tdata <= {pending_pixels[0].mv, pending_pixels[0].la, pending_pixels[0].lb,
                    pending_pixels[0].lg, pending_pixels[0].lr, pending_pixels[0].ba,
                    pending_pixels[0].bb, pending_pixels[0].bg, pending_pixels[0].br};
        s_tlast <= pending_pixels[0].last;
      end else begin
        s_tvalid <= 1'b0;
        if (pending_pixels.size() > 0 && !calm) src_gap = $urandom_range(0, 18);
      end
    end
  end

  // sink backpressure, including one long hold counted here
  int sink_gap = 0;
  int hold_count = 0;
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_sink) begin
      m_tready <= 1'b0;
      hold_count++;
      if (hold_count >= SINK_HOLD_CYCLES) begin
        hold_count = 0;
        hold_sink = 1'b0;
      end
    end else if (calm) begin
      m_tready <= 1'b1;
    end else if (sink_gap > 0) begin
      sink_gap--;
      m_tready <= 1'b0;
    end else if ($urandom_range(0, 15) == 0) begin
      sink_gap = $urandom_range(0, 18);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // monitor: predicts on input transaction, checks on output transaction
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        expected_pixels.push_back(dodge_blend(pix_in_t'({s_tdata[0*CW+:CW], s_tdata[1*CW+:CW],
          s_tdata[2*CW+:CW], s_tdata[3*CW+:CW], s_tdata[4*CW+:CW], s_tdata[5*CW+:CW],
          s_tdata[6*CW+:CW], s_tdata[7*CW+:CW], s_tdata[8*CW+:CW], s_tlast})));
        pixels_sent++;
      end
      if (m_tvalid && m_tready) begin
        pix_out_t want;
        pixels_seen++;
        if (expected_pixels.size() == 0) begin
          errors++;
          $display("unexpected result transaction %0d", pixels_seen);
        end else begin
          want = expected_pixels.pop_front();
          if (m_tdata[0*CW+:CW] !== want.r) report_mismatch("red", m_tdata[0*CW+:CW], want.r);
          if (m_tdata[1*CW+:CW] !== want.g) report_mismatch("green", m_tdata[1*CW+:CW], want.g);
          if (m_tdata[2*CW+:CW] !== want.b) report_mismatch("blue", m_tdata[2*CW+:CW], want.b);
          if (m_tdata[3*CW+:CW] !== want.a) report_mismatch("alpha", m_tdata[3*CW+:CW], want.a);
          if (m_tlast !== want.last) report_mismatch("last", CW'(m_tlast), CW'(want.last));
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired after %0d idle cycles", idle_cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic logic [CW-1:0] rand_val();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return ONE;
      2: return CW'($urandom_range(0, 15));
      3: return ONE - CW'($urandom_range(0, 15));
      default: return CW'($urandom);
    endcase
  endfunction

  function automatic pix_in_t rand_pixel();
    pix_in_t p;
    p = '0;
    p.br = rand_val(); p.bg = rand_val(); p.bb = rand_val(); p.ba = rand_val();
    p.lr = rand_val(); p.lg = rand_val(); p.lb = rand_val(); p.la = rand_val();
    p.mv = rand_val();
    p.last = ($urandom_range(0, 7) == 0);
    return p;
  endfunction

  task automatic write_reg(input logic idx, input logic [CW-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_OPACITY) opacity_q = val;
    else mask_en_q = val[0];
  endtask

  task automatic wait_drained();
    while (pending_pixels.size() > 0 || s_tvalid || expected_pixels.size() > 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // settings per phase: opacity, mask enable
  logic [CW-1:0] phase_opacity[6] = '{ONE, '0, 16'h8000, ONE, 16'h0001, 16'h5a5a};
  logic          phase_mask[6] = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0};

  initial begin
    pix_in_t p;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // directed corners at reset settings
    for (int i = 0; i < 20; i++) begin
      p = rand_pixel();
      case (i)
        0: p = '0;
        1: p = '1;
        2: p = {ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, 1'b1};
        3: begin p.br = '0; p.lr = ONE; p.ba = ONE; p.la = ONE; end
        4: begin p.ba = '0; p.la = ONE; end
        5: begin p.la = '0; end
        6: begin p.lr = ONE - 1'b1; p.br = ONE; p.ba = 16'h8000; p.la = 16'h8000; end
        default: ;
      endcase
      pending_pixels.push_back(p);
    end
    wait_drained();
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_OPACITY, phase_opacity[ph]);
      write_reg(REG_MASK_EN, CW'(phase_mask[ph]));
      if (ph == 2) begin
        // long receiver stall while the source keeps pushing
        hold_sink = 1'b1;
        for (int i = 0; i < 80; i++) pending_pixels.push_back(rand_pixel());
        wait (!hold_sink);
      end
      if (ph == 5) calm = 1'b1;
      for (int i = 0; i < 290; i++) pending_pixels.push_back(rand_pixel());
      wait_drained();
    end
    $display("covered %0d pixels at reset settings and six opacity and mask settings,",
             pixels_sent);
    $display("with random gaps on both sides and one long output stall");
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/cdlb_pkg.sv
rtl/cdlb_divider.sv
rtl/cdlb_alpha.sv
rtl/cdlb_lane.sv
rtl/color_dodge_layer_blend.sv
tb/color_dodge_layer_blend_tb.sv
